/* sv/scalar_mips_subset_executor_top_macros.svh */
// Assertion macros shared by the executor RTL.
// Depends on nothing; included by sme_back, the module that carries assertions.
`ifndef SCALAR_MIPS_SUBSET_EXECUTOR_TOP_MACROS_SVH
`define SCALAR_MIPS_SUBSET_EXECUTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sme_pkg.sv */
// Shared types and constants of the scalar MIPS subset executor.
// Depends on nothing; used by every module of the block.
package sme_pkg;

    localparam int REG_COUNT = 32;
    localparam int PC_W      = 12;

    // Configuration register indexes
    localparam logic CFG_START_ADDRESS = 1'b0;
    localparam logic CFG_BREAK_IRQ_EN  = 1'b1;

    // Primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_REGIMM  = 6'h01;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_BLEZ    = 6'h06;
    localparam logic [5:0] OPC_BGTZ    = 6'h07;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTI    = 6'h0a;
    localparam logic [5:0] OPC_SLTIU   = 6'h0b;
    localparam logic [5:0] OPC_ANDI    = 6'h0c;
    localparam logic [5:0] OPC_ORI     = 6'h0d;
    localparam logic [5:0] OPC_XORI    = 6'h0e;
    localparam logic [5:0] OPC_LUI     = 6'h0f;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LH      = 6'h21;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_LBU     = 6'h24;
    localparam logic [5:0] OPC_LHU     = 6'h25;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SH      = 6'h29;
    localparam logic [5:0] OPC_SW      = 6'h2b;
    localparam logic [5:0] OPC_CACHE   = 6'h2f;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_BREAK = 6'h0d;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2a;
    localparam logic [5:0] FN_SLTU  = 6'h2b;

    // REGIMM rt codes
    localparam logic [4:0] RT_BLTZ   = 5'h00;
    localparam logic [4:0] RT_BGEZ   = 5'h01;
    localparam logic [4:0] RT_BLTZAL = 5'h10;
    localparam logic [4:0] RT_BGEZAL = 5'h11;

    localparam logic [4:0] LINK_REG = 5'd31;

    // Store sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef enum logic [5:0] {
        OP_NOP, OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_JR, OP_JALR,
        OP_BREAK, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
        OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_J, OP_JAL, OP_BEQ, OP_BNE,
        OP_BLEZ, OP_BGTZ, OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
        OP_LUI, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW,
        OP_UNSUP, OP_RESTART
    } t_op;

    typedef enum logic [2:0] {
        LD_NONE, LD_B, LD_BU, LD_H, LD_HU, LD_W
    } t_ld;

    typedef struct packed {
        t_op         op;
        logic [31:0] instr;
    } t_item;

    typedef struct packed {
        logic [11:0] start_address;
        logic        break_interrupt_enable;
    } t_cfg;

    typedef struct packed {
        logic [11:0] fetch_address;
        logic        halted;
        logic        break_interrupt;
        logic        unsupported;
        logic        misaligned;
        logic        reg_write_enable;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        mem_write_enable;
        logic [11:0] mem_write_address;
        logic [31:0] mem_write_data;
        logic [1:0]  mem_write_size;
    } t_result;

endpackage

/* sv/sme_front.sv */
// Front end: accepts items, classifies each instruction, queues them for the back end.
// Depends on sme_pkg.
module sme_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [31:0]          i_instruction,
    input  logic                 i_hold,
    input  logic                 i_pop,
    output logic                 o_head_valid,
    output sme_pkg::t_item       o_head
);

    // Map one item to its operation class
    function automatic sme_pkg::t_op classify(input logic restart, input logic [31:0] ins);
        sme_pkg::t_op op;
        op = sme_pkg::OP_UNSUP;
        if (restart) begin
            op = sme_pkg::OP_RESTART;
        end else begin
            unique case (ins[31:26]) inside
                sme_pkg::OPC_SPECIAL: begin
                    unique case (ins[5:0]) inside
                        sme_pkg::FN_SLL:                 op = sme_pkg::OP_SLL;
                        sme_pkg::FN_SRL:                 op = sme_pkg::OP_SRL;
                        sme_pkg::FN_SRA:                 op = sme_pkg::OP_SRA;
                        sme_pkg::FN_SLLV:                op = sme_pkg::OP_SLLV;
                        sme_pkg::FN_SRLV:                op = sme_pkg::OP_SRLV;
                        sme_pkg::FN_SRAV:                op = sme_pkg::OP_SRAV;
                        sme_pkg::FN_JR:                  op = sme_pkg::OP_JR;
                        sme_pkg::FN_JALR:                op = sme_pkg::OP_JALR;
                        sme_pkg::FN_BREAK:               op = sme_pkg::OP_BREAK;
                        sme_pkg::FN_ADD, sme_pkg::FN_ADDU: op = sme_pkg::OP_ADD;
                        sme_pkg::FN_SUB, sme_pkg::FN_SUBU: op = sme_pkg::OP_SUB;
                        sme_pkg::FN_AND:                 op = sme_pkg::OP_AND;
                        sme_pkg::FN_OR:                  op = sme_pkg::OP_OR;
                        sme_pkg::FN_XOR:                 op = sme_pkg::OP_XOR;
                        sme_pkg::FN_NOR:                 op = sme_pkg::OP_NOR;
                        sme_pkg::FN_SLT:                 op = sme_pkg::OP_SLT;
                        sme_pkg::FN_SLTU:                op = sme_pkg::OP_SLTU;
                        default:                         op = sme_pkg::OP_UNSUP;
                    endcase
                end
                sme_pkg::OPC_REGIMM: begin
                    unique case (ins[20:16]) inside
                        sme_pkg::RT_BLTZ:   op = sme_pkg::OP_BLTZ;
                        sme_pkg::RT_BGEZ:   op = sme_pkg::OP_BGEZ;
                        sme_pkg::RT_BLTZAL: op = sme_pkg::OP_BLTZAL;
                        sme_pkg::RT_BGEZAL: op = sme_pkg::OP_BGEZAL;
                        default:            op = sme_pkg::OP_UNSUP;
                    endcase
                end
                sme_pkg::OPC_J:                      op = sme_pkg::OP_J;
                sme_pkg::OPC_JAL:                    op = sme_pkg::OP_JAL;
                sme_pkg::OPC_BEQ:                    op = sme_pkg::OP_BEQ;
                sme_pkg::OPC_BNE:                    op = sme_pkg::OP_BNE;
                sme_pkg::OPC_BLEZ:                   op = sme_pkg::OP_BLEZ;
                sme_pkg::OPC_BGTZ:                   op = sme_pkg::OP_BGTZ;
                sme_pkg::OPC_ADDI, sme_pkg::OPC_ADDIU: op = sme_pkg::OP_ADDI;
                sme_pkg::OPC_SLTI:                   op = sme_pkg::OP_SLTI;
                sme_pkg::OPC_SLTIU:                  op = sme_pkg::OP_SLTIU;
                sme_pkg::OPC_ANDI:                   op = sme_pkg::OP_ANDI;
                sme_pkg::OPC_ORI:                    op = sme_pkg::OP_ORI;
                sme_pkg::OPC_XORI:                   op = sme_pkg::OP_XORI;
                sme_pkg::OPC_LUI:                    op = sme_pkg::OP_LUI;
                sme_pkg::OPC_LB:                     op = sme_pkg::OP_LB;
                sme_pkg::OPC_LBU:                    op = sme_pkg::OP_LBU;
                sme_pkg::OPC_LH:                     op = sme_pkg::OP_LH;
                sme_pkg::OPC_LHU:                    op = sme_pkg::OP_LHU;
                sme_pkg::OPC_LW:                     op = sme_pkg::OP_LW;
                sme_pkg::OPC_SB:                     op = sme_pkg::OP_SB;
                sme_pkg::OPC_SH:                     op = sme_pkg::OP_SH;
                sme_pkg::OPC_SW:                     op = sme_pkg::OP_SW;
                sme_pkg::OPC_CACHE:                  op = sme_pkg::OP_NOP;
                default:                             op = sme_pkg::OP_UNSUP;
            endcase
        end
        return op;
    endfunction

    sme_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    sme_pkg::t_item in_item;

    assign o_in_ready   = !i_hold && (r_cnt != 2'd2);
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        in_item.op    = classify(i_operation, i_instruction);
        in_item.instr = i_instruction;
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

/* sv/sme_back.sv */
// Back end: operand read, execute with branch and halt state, data memory, writeback.
// Depends on sme_pkg and the shared assertion macro header.
`include "scalar_mips_subset_executor_top_macros.svh"
module sme_back #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sme_pkg::t_cfg    i_cfg,
    input  logic             i_head_valid,
    input  sme_pkg::t_item   i_head,
    output logic             o_pop,
    output logic             o_clearing,
    input  logic             i_out_space,
    output logic             o_push,
    output sme_pkg::t_result o_result
);

    localparam int          AW      = $clog2(DMEM_BYTES);
    localparam int          WORDS   = DMEM_BYTES / 4;
    localparam int          WAW     = AW - 2;
    localparam logic [31:0] DM_MASK = 32'(DMEM_BYTES - 1);

    // Register file, data memory and their control
    logic [31:0]                   rf [sme_pkg::REG_COUNT];
    logic [sme_pkg::REG_COUNT-1:0] r_rf_vld;
    logic [31:0]                   dmem [WORDS];
    logic                          r_clr;
    logic [WAW-1:0]                r_clr_idx;

    // Architectural state
    logic [11:0] r_pc;
    logic        r_halt;
    logic        r_bpend;
    logic [11:0] r_btarget;

    // Execute stage
    logic           r_x_valid;
    sme_pkg::t_item r_x_item;
    logic [31:0]    r_rfa;
    logic [31:0]    r_rfb;
    logic           r_rfa_v;
    logic           r_rfb_v;

    // Writeback stage
    logic             r_w_valid;
    sme_pkg::t_result r_w_res;
    logic             r_w_we;
    logic [4:0]       r_w_idx;
    sme_pkg::t_ld     r_w_ld;
    logic [1:0]       r_w_off;
    logic [31:0]      r_mem_q;

    // Last retired register write
    logic        r_l_we;
    logic [4:0]  r_l_idx;
    logic [31:0] r_l_val;

    logic adv;
    logic [4:0]  x_rs, x_rt, x_rd, x_sh;
    logic [15:0] x_imm;
    logic [31:0] x_simm, x_zimm, x_a, x_b, x_sum, x_ea, x_link;
    logic [11:0] x_seq;
    logic [WAW-1:0] x_word;
    logic [31:0] w_value;
    logic [7:0]  w_byte;
    logic [15:0] w_half;

    logic [11:0] n_pc, n_btarget, ntarget;
    logic        n_halt, n_bpend, npend, take;
    sme_pkg::t_result x_res;
    logic        wr_req, x_wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    sme_pkg::t_ld ld_req, x_ld;
    logic        st_req;
    logic [3:0]  st_be;
    logic [31:0] st_data;

    logic           m_we;
    logic [WAW-1:0] m_idx;
    logic [3:0]     m_be;
    logic [31:0]    m_data;

    assign adv        = i_out_space && !r_clr;
    assign o_pop      = adv && i_head_valid;
    assign o_push     = adv && r_w_valid;
    assign o_clearing = r_clr;

    // Operand fields and forwarding
    assign x_rs   = r_x_item.instr[25:21];
    assign x_rt   = r_x_item.instr[20:16];
    assign x_rd   = r_x_item.instr[15:11];
    assign x_sh   = r_x_item.instr[10:6];
    assign x_imm  = r_x_item.instr[15:0];
    assign x_simm = {{16{x_imm[15]}}, x_imm};
    assign x_zimm = {16'b0, x_imm};

    always_comb begin
        if (r_w_valid && r_w_we && r_w_idx == x_rs) begin
            x_a = w_value;
        end else if (r_l_we && r_l_idx == x_rs) begin
            x_a = r_l_val;
        end else begin
            x_a = r_rfa_v ? r_rfa : 32'b0;
        end
        if (r_w_valid && r_w_we && r_w_idx == x_rt) begin
            x_b = w_value;
        end else if (r_l_we && r_l_idx == x_rt) begin
            x_b = r_l_val;
        end else begin
            x_b = r_rfb_v ? r_rfb : 32'b0;
        end
    end

    assign x_sum  = x_a + x_simm;
    assign x_ea   = x_sum & DM_MASK;
    assign x_word = x_ea[AW-1:2];
    assign x_seq  = r_pc + 12'd4;
    assign x_link = {20'b0, 12'(r_pc + 12'd8)};

    // Execute one instruction
    always_comb begin
        n_pc      = r_pc;
        n_halt    = r_halt;
        n_bpend   = r_bpend;
        n_btarget = r_btarget;
        x_res     = '0;
        wr_req    = 1'b0;
        wr_idx    = '0;
        wr_val    = '0;
        ld_req    = sme_pkg::LD_NONE;
        take      = 1'b0;
        npend     = 1'b0;
        ntarget   = '0;
        st_req    = 1'b0;
        st_be     = '0;
        st_data   = '0;
        if (r_x_item.op == sme_pkg::OP_RESTART) begin
            n_pc    = i_cfg.start_address;
            n_halt  = 1'b0;
            n_bpend = 1'b0;
        end else if (!r_halt) begin
            x_res.misaligned = (r_pc[1:0] != 2'b00);
            unique case (r_x_item.op)
                sme_pkg::OP_SLL: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_b << x_sh;
                end
                sme_pkg::OP_SRL: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_b >> x_sh;
                end
                sme_pkg::OP_SRA: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = $unsigned($signed(x_b) >>> x_sh);
                end
                sme_pkg::OP_SLLV: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_b << x_a[4:0];
                end
                sme_pkg::OP_SRLV: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_b >> x_a[4:0];
                end
                sme_pkg::OP_SRAV: begin
                    wr_req = 1'b1; wr_idx = x_rd;
                    wr_val = $unsigned($signed(x_b) >>> x_a[4:0]);
                end
                sme_pkg::OP_JR: begin
                    npend = 1'b1; ntarget = x_a[11:0];
                end
                sme_pkg::OP_JALR: begin
                    npend = 1'b1; ntarget = x_a[11:0];
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_link;
                end
                sme_pkg::OP_BREAK: begin
                    n_halt = 1'b1;
                    x_res.break_interrupt = i_cfg.break_interrupt_enable;
                end
                sme_pkg::OP_ADD: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_a + x_b;
                end
                sme_pkg::OP_SUB: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_a - x_b;
                end
                sme_pkg::OP_AND: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_a & x_b;
                end
                sme_pkg::OP_OR: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_a | x_b;
                end
                sme_pkg::OP_XOR: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = x_a ^ x_b;
                end
                sme_pkg::OP_NOR: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = ~(x_a | x_b);
                end
                sme_pkg::OP_SLT: begin
                    wr_req = 1'b1; wr_idx = x_rd;
                    wr_val = {31'b0, ($signed(x_a) < $signed(x_b))};
                end
                sme_pkg::OP_SLTU: begin
                    wr_req = 1'b1; wr_idx = x_rd; wr_val = {31'b0, (x_a < x_b)};
                end
                sme_pkg::OP_BLTZ: take = x_a[31];
                sme_pkg::OP_BGEZ: take = !x_a[31];
                sme_pkg::OP_BLTZAL: begin
                    take = x_a[31];
                    wr_req = 1'b1; wr_idx = sme_pkg::LINK_REG; wr_val = x_link;
                end
                sme_pkg::OP_BGEZAL: begin
                    take = !x_a[31];
                    wr_req = 1'b1; wr_idx = sme_pkg::LINK_REG; wr_val = x_link;
                end
                sme_pkg::OP_J: begin
                    npend = 1'b1; ntarget = {r_x_item.instr[9:0], 2'b00};
                end
                sme_pkg::OP_JAL: begin
                    npend = 1'b1; ntarget = {r_x_item.instr[9:0], 2'b00};
                    wr_req = 1'b1; wr_idx = sme_pkg::LINK_REG; wr_val = x_link;
                end
                sme_pkg::OP_BEQ:  take = (x_a == x_b);
                sme_pkg::OP_BNE:  take = (x_a != x_b);
                sme_pkg::OP_BLEZ: take = (x_a == 32'b0) || x_a[31];
                sme_pkg::OP_BGTZ: take = (x_a != 32'b0) && !x_a[31];
                sme_pkg::OP_ADDI: begin
                    wr_req = 1'b1; wr_idx = x_rt; wr_val = x_sum;
                end
                sme_pkg::OP_SLTI: begin
                    wr_req = 1'b1; wr_idx = x_rt;
                    wr_val = {31'b0, ($signed(x_a) < $signed(x_simm))};
                end
                sme_pkg::OP_SLTIU: begin
                    wr_req = 1'b1; wr_idx = x_rt; wr_val = {31'b0, (x_a < x_simm)};
                end
                sme_pkg::OP_ANDI: begin
                    wr_req = 1'b1; wr_idx = x_rt; wr_val = x_a & x_zimm;
                end
                sme_pkg::OP_ORI: begin
                    wr_req = 1'b1; wr_idx = x_rt; wr_val = x_a | x_zimm;
                end
                sme_pkg::OP_XORI: begin
                    wr_req = 1'b1; wr_idx = x_rt; wr_val = x_a ^ x_zimm;
                end
                sme_pkg::OP_LUI: begin
                    wr_req = 1'b1; wr_idx = x_rt; wr_val = {x_imm, 16'b0};
                end
                sme_pkg::OP_LB: begin
                    wr_req = 1'b1; wr_idx = x_rt; ld_req = sme_pkg::LD_B;
                end
                sme_pkg::OP_LBU: begin
                    wr_req = 1'b1; wr_idx = x_rt; ld_req = sme_pkg::LD_BU;
                end
                sme_pkg::OP_LH: begin
                    if (x_sum[0]) begin
                        x_res.misaligned = 1'b1;
                    end else begin
                        wr_req = 1'b1; wr_idx = x_rt; ld_req = sme_pkg::LD_H;
                    end
                end
                sme_pkg::OP_LHU: begin
                    if (x_sum[0]) begin
                        x_res.misaligned = 1'b1;
                    end else begin
                        wr_req = 1'b1; wr_idx = x_rt; ld_req = sme_pkg::LD_HU;
                    end
                end
                sme_pkg::OP_LW: begin
                    if (x_sum[1:0] != 2'b00) begin
                        x_res.misaligned = 1'b1;
                    end else begin
                        wr_req = 1'b1; wr_idx = x_rt; ld_req = sme_pkg::LD_W;
                    end
                end
                sme_pkg::OP_SB: begin
                    st_req  = 1'b1;
                    st_be   = 4'b1000 >> x_ea[1:0];
                    st_data = {4{x_b[7:0]}};
                    x_res.mem_write_enable  = 1'b1;
                    x_res.mem_write_address = x_ea[11:0];
                    x_res.mem_write_data    = {24'b0, x_b[7:0]};
                    x_res.mem_write_size    = sme_pkg::SIZE_BYTE;
                end
                sme_pkg::OP_SH: begin
                    if (x_sum[0]) begin
                        x_res.misaligned = 1'b1;
                    end else begin
                        st_req  = 1'b1;
                        st_be   = x_ea[1] ? 4'b0011 : 4'b1100;
                        st_data = {2{x_b[15:0]}};
                        x_res.mem_write_enable  = 1'b1;
                        x_res.mem_write_address = x_ea[11:0];
                        x_res.mem_write_data    = {16'b0, x_b[15:0]};
                        x_res.mem_write_size    = sme_pkg::SIZE_HALF;
                    end
                end
                sme_pkg::OP_SW: begin
                    if (x_sum[1:0] != 2'b00) begin
                        x_res.misaligned = 1'b1;
                    end else begin
                        st_req  = 1'b1;
                        st_be   = 4'b1111;
                        st_data = x_b;
                        x_res.mem_write_enable  = 1'b1;
                        x_res.mem_write_address = x_ea[11:0];
                        x_res.mem_write_data    = x_b;
                        x_res.mem_write_size    = sme_pkg::SIZE_WORD;
                    end
                end
                sme_pkg::OP_UNSUP: x_res.unsupported = 1'b1;
                default: ;
            endcase
            if (take) begin
                npend   = 1'b1;
                ntarget = x_seq + {x_imm[9:0], 2'b00};
            end
            n_pc      = r_bpend ? r_btarget : x_seq;
            n_bpend   = npend;
            n_btarget = ntarget;
        end
        x_wr_en = wr_req && (wr_idx != 5'd0);
        x_ld    = x_wr_en ? ld_req : sme_pkg::LD_NONE;
        if (x_wr_en) begin
            x_res.reg_write_enable = 1'b1;
            x_res.reg_write_index  = wr_idx;
            x_res.reg_write_value  = wr_val;
        end
        x_res.fetch_address = n_pc;
        x_res.halted        = n_halt;
    end

    // Update architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_halt    <= 1'b1;
            r_bpend   <= 1'b0;
            r_btarget <= '0;
        end else if (adv && r_x_valid) begin
            r_pc      <= n_pc;
            r_halt    <= n_halt;
            r_bpend   <= n_bpend;
            r_btarget <= n_btarget;
        end
    end

    // Stage valids, clearing pass and last-write tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_w_valid <= 1'b0;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_l_we    <= 1'b0;
            r_rf_vld  <= '0;
        end else begin
            if (adv) begin
                r_x_valid <= i_head_valid;
                r_w_valid <= r_x_valid;
            end
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == WAW'(WORDS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (o_push && r_w_we) begin
                r_l_we             <= 1'b1;
                r_rf_vld[r_w_idx]  <= 1'b1;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_item <= i_head;
            r_w_res  <= x_res;
            r_w_we   <= r_x_valid && x_wr_en;
            r_w_idx  <= wr_idx;
            r_w_ld   <= x_ld;
            r_w_off  <= x_ea[1:0];
        end
        if (o_push && r_w_we) begin
            r_l_idx <= r_w_idx;
            r_l_val <= w_value;
        end
    end

    // Register file: read on entry to execute, write on retire
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rfa   <= rf[i_head.instr[25:21]];
            r_rfb   <= rf[i_head.instr[20:16]];
            r_rfa_v <= r_rf_vld[i_head.instr[25:21]];
            r_rfb_v <= r_rf_vld[i_head.instr[20:16]];
        end
        if (o_push && r_w_we) begin
            rf[r_w_idx] <= w_value;
        end
    end

    // Data memory port: clearing pass or store, one word read for loads
    assign m_we   = r_clr || (adv && r_x_valid && st_req);
    assign m_idx  = r_clr ? r_clr_idx : x_word;
    assign m_be   = r_clr ? 4'b1111 : st_be;
    assign m_data = r_clr ? 32'b0 : st_data;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            for (int l = 0; l < 4; l++) begin
                if (m_be[l]) begin
                    dmem[m_idx][8*l +: 8] <= m_data[8*l +: 8];
                end
            end
        end
        if (adv) begin
            r_mem_q <= dmem[x_word];
        end
    end

    // Align load data, big-endian lanes
    always_comb begin
        case (r_w_off)
            2'd0:    w_byte = r_mem_q[31:24];
            2'd1:    w_byte = r_mem_q[23:16];
            2'd2:    w_byte = r_mem_q[15:8];
            default: w_byte = r_mem_q[7:0];
        endcase
        w_half = r_w_off[1] ? r_mem_q[15:0] : r_mem_q[31:16];
        unique case (r_w_ld)
            sme_pkg::LD_B:  w_value = {{24{w_byte[7]}}, w_byte};
            sme_pkg::LD_BU: w_value = {24'b0, w_byte};
            sme_pkg::LD_H:  w_value = {{16{w_half[15]}}, w_half};
            sme_pkg::LD_HU: w_value = {16'b0, w_half};
            sme_pkg::LD_W:  w_value = r_mem_q;
            default:        w_value = r_w_res.reg_write_value;
        endcase
    end

    always_comb begin
        o_result                 = r_w_res;
        o_result.reg_write_value = w_value;
    end

    `SME_ASSERT_SAME(a_r0_never_written, i_clk, i_rst_n, r_w_valid && r_w_we, r_w_idx != 5'd0, "retired write to r0")
    `SME_ASSERT_SAME(a_idle_while_clearing, i_clk, i_rst_n, r_clr, !i_head_valid && !r_x_valid && !r_w_valid, "item present during memory clear")
    `SME_ASSERT_NEXT(a_break_halts, i_clk, i_rst_n, adv && r_x_valid && !r_halt && r_x_item.op == sme_pkg::OP_BREAK, r_halt, "break did not halt")
    `SME_ASSERT_SAME(a_no_store_when_halted, i_clk, i_rst_n, r_w_valid && r_w_res.halted, !r_w_res.mem_write_enable, "store reported with halt")

endmodule

/* sv/sme_outq.sv */
// Result queue between the back end and the output channel.
// Depends on sme_pkg.
module sme_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sme_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output sme_pkg::t_result o_data
);

    sme_pkg::t_result r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign pop     = o_valid && i_ready;

    // Hold results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

endmodule

/* sv/scalar_mips_subset_executor_top.sv */
// Top level of the scalar MIPS subset executor: configuration registers and the three parts.
// Depends on sme_pkg, sme_front, sme_back and sme_outq.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-------------------------------------------
//  in       | i_in_valid / o_in_ready     | i_operation, i_instruction
//  out      | o_out_valid / i_out_ready   | o_fetch_address .. o_mem_write_size
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled and no clearing pass runs; a result
// passes the front queue, execute stage, writeback stage and result queue in that order.
// After reset the data memory is cleared one word a cycle, DMEM_BYTES/4 words in all, with
// o_in_ready low throughout.
// A stalled output stops the back end once the result queue is full; the front queue
// keeps taking items until it too is full.
module scalar_mips_subset_executor_top #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [31:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_fetch_address,
    output logic        o_halted,
    output logic        o_break_interrupt,
    output logic        o_unsupported,
    output logic        o_misaligned,
    output logic        o_reg_write_enable,
    output logic [4:0]  o_reg_write_index,
    output logic [31:0] o_reg_write_value,
    output logic        o_mem_write_enable,
    output logic [11:0] o_mem_write_address,
    output logic [31:0] o_mem_write_data,
    output logic [1:0]  o_mem_write_size,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sme_pkg::t_cfg    r_cfg;
    logic             head_valid;
    sme_pkg::t_item   head;
    logic             pop;
    logic             clearing;
    logic             out_space;
    logic             push;
    sme_pkg::t_result result;
    sme_pkg::t_result out_data;

    assign pready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                sme_pkg::CFG_START_ADDRESS: r_cfg.start_address          <= pwdata[11:0];
                sme_pkg::CFG_BREAK_IRQ_EN:  r_cfg.break_interrupt_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (paddr[2])
            sme_pkg::CFG_START_ADDRESS: prdata = {20'b0, r_cfg.start_address};
            sme_pkg::CFG_BREAK_IRQ_EN:  prdata = {31'b0, r_cfg.break_interrupt_enable};
            default:                    prdata = 32'b0;
        endcase
    end

    sme_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_instruction (i_instruction),
        .i_hold        (clearing),
        .i_pop         (pop),
        .o_head_valid  (head_valid),
        .o_head        (head)
    );

    sme_back #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .i_out_space  (out_space),
        .o_push       (push),
        .o_result     (result)
    );

    sme_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_fetch_address     = out_data.fetch_address;
    assign o_halted            = out_data.halted;
    assign o_break_interrupt   = out_data.break_interrupt;
    assign o_unsupported       = out_data.unsupported;
    assign o_misaligned        = out_data.misaligned;
    assign o_reg_write_enable  = out_data.reg_write_enable;
    assign o_reg_write_index   = out_data.reg_write_index;
    assign o_reg_write_value   = out_data.reg_write_value;
    assign o_mem_write_enable  = out_data.mem_write_enable;
    assign o_mem_write_address = out_data.mem_write_address;
    assign o_mem_write_data    = out_data.mem_write_data;
    assign o_mem_write_size    = out_data.mem_write_size;

endmodule
